// ===== hw/rtl/gda_pkg.sv =====
// Package for the Gregorian date adder: shared constants and calendar helpers.
// Used by the top level.
package gda_pkg;

  localparam int unsigned DayW   = 5;
  localparam int unsigned MonthW = 4;
  localparam int unsigned YearW  = 14;
  localparam int unsigned AddW   = 15;
  // Internal sum: day of year plus offset, up to about 33200.
  localparam int unsigned SumW   = 17;

  // Days before the first of each month in a common year; months 13..15 give a full year.
  function automatic logic [8:0] days_before(input logic [MonthW-1:0] m);
    logic [8:0] r;
    case (m)
      4'd0, 4'd1: r = 9'd0;
      4'd2:  r = 9'd31;
      4'd3:  r = 9'd59;
      4'd4:  r = 9'd90;
      4'd5:  r = 9'd120;
      4'd6:  r = 9'd151;
      4'd7:  r = 9'd181;
      4'd8:  r = 9'd212;
      4'd9:  r = 9'd243;
      4'd10: r = 9'd273;
      4'd11: r = 9'd304;
      4'd12: r = 9'd334;
      default: r = 9'd365;
    endcase
    return r;
  endfunction

endpackage

// ===== hw/rtl/gda_if.sv =====
// Valid/ready channel interface carrying a generic payload.
// Depends on nothing; the payload width is a parameter.
interface gda_if #(
  parameter int unsigned W = 1
);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/gregorian_date_add_days.sv =====
// Top level of the Gregorian date adder: a walking pipeline that peels years
// then months off a day count. Depends on gda_pkg and gda_if.
//
// Usage: items enter on in_ch with payload {start_day, start_month, start_year,
// days_to_add}, day in the top bits. Results leave on out_ch with payload
// {result_day, result_month, result_year}. One result per item, in order.
// Each item passes through the entry stage, the year stages and then the month
// stages. Throughput: one item every cycle while the receiver keeps ready high.
// Every stage is registered and holds while the stage after it is full and
// stalled. The depth is set by the year walk: one entry stage, one stage per
// year of the largest offset (91), then twelve month stages. Reset clears all
// valid bits; the stage data registers are not reset.
// When the receiver stalls, items queue in the stages and ready drops once the
// whole pipe is full.
module gregorian_date_add_days (
  input  logic  clk,
  input  logic  rst,
  gda_if.sink   in_ch,
  gda_if.source out_ch
);

  localparam int unsigned YS = 91;  // year stages: 91*365 > max sum
  localparam int unsigned MS = 12;
  localparam int unsigned N  = YS + MS + 1;

  // The year is tracked both as the visible 14-bit count and as its place in
  // the century plus the century count modulo 4, which is all the leap rule needs.
  typedef struct packed {
    logic [gda_pkg::SumW-1:0]   rem;
    logic [gda_pkg::YearW-1:0]  year;
    logic [gda_pkg::MonthW-1:0] month;
    logic [6:0]                 cent_year;
    logic [1:0]                 cent_mod4;
  } st_t;

  st_t  s      [N];
  st_t  s_next [N];
  logic v      [N];
  logic adv    [N];

  // Leap rule from the year within its century and the century count modulo 4.
  function automatic logic leap(input logic [6:0] cy, input logic [1:0] cm);
    return (cy != 7'd0) ? (cy[1:0] == 2'b00) : (cm == 2'b00);
  endfunction

  // Stage 0: split the year by 100 with a reciprocal multiply, then the day
  // of year plus offset.
  logic [gda_pkg::DayW-1:0]   d_in;
  logic [gda_pkg::MonthW-1:0] m_in;
  logic [gda_pkg::YearW-1:0]  y_in;
  logic [gda_pkg::AddW-1:0]   a_in;
  logic [7:0]                 q0;
  logic [6:0]                 r0;
  logic [gda_pkg::SumW-1:0]   sum0;
  assign {d_in, m_in, y_in, a_in} = in_ch.data;
  assign q0 = 8'((27'(y_in) * 27'd5243) >> 19);
  assign r0 = 7'(y_in - 14'(q0) * 14'd100);
  always_comb begin
    sum0 = gda_pkg::SumW'(gda_pkg::days_before(m_in)) + gda_pkg::SumW'(d_in)
         + gda_pkg::SumW'(a_in);
    if (m_in > 4'd2 && leap(r0, q0[1:0])) begin
      sum0 = sum0 + gda_pkg::SumW'(1);
    end
  end

  // Stage i advances when the next one can take its item.
  always_comb begin
    adv[N-1] = !v[N-1] || out_ch.ready;
    for (int i = int'(N) - 2; i >= 0; i--) begin
      adv[i] = !v[i] || adv[i+1];
    end
  end
  assign in_ch.ready = adv[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < N; i++) begin
        v[i] <= 1'b0;
      end
    end else begin
      if (adv[0]) begin
        v[0] <= in_ch.valid;
      end
      for (int i = 1; i < N; i++) begin
        if (adv[i]) begin
          v[i] <= v[i-1];
        end
      end
    end
  end

  // Stage logic: year peel, then month peel with month kept from January.
  always_comb begin
    logic [gda_pkg::SumW-1:0] len;
    logic [gda_pkg::SumW-1:0] ylen;
    len  = '0;
    ylen = '0;
    s_next[0].rem       = sum0;
    s_next[0].year      = y_in;
    s_next[0].month     = 4'd1;
    s_next[0].cent_year = r0;
    s_next[0].cent_mod4 = q0[1:0];
    for (int i = 1; i < N; i++) begin
      s_next[i] = s[i-1];
      if (i <= int'(YS)) begin
        ylen = leap(s[i-1].cent_year, s[i-1].cent_mod4) ? gda_pkg::SumW'(366)
                                                        : gda_pkg::SumW'(365);
        if (s[i-1].rem > ylen) begin
          s_next[i].rem  = s[i-1].rem - ylen;
          s_next[i].year = s[i-1].year + gda_pkg::YearW'(1);
          if (s[i-1].cent_year == 7'd99) begin
            s_next[i].cent_year = 7'd0;
            s_next[i].cent_mod4 = s[i-1].cent_mod4 + 2'd1;
          end else begin
            s_next[i].cent_year = s[i-1].cent_year + 7'd1;
          end
        end
      end else if (s[i-1].month < 4'd12) begin
        len = gda_pkg::SumW'(gda_pkg::days_before(s[i-1].month + 4'd1)
              - gda_pkg::days_before(s[i-1].month));
        if (s[i-1].month == 4'd2 && leap(s[i-1].cent_year, s[i-1].cent_mod4)) begin
          len = len + gda_pkg::SumW'(1);
        end
        if (s[i-1].rem > len) begin
          s_next[i].rem   = s[i-1].rem - len;
          s_next[i].month = s[i-1].month + 4'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < N; i++) begin
      if (adv[i]) begin
        s[i] <= s_next[i];
      end
    end
  end

  assign out_ch.valid = v[N-1];
  assign out_ch.data  = {s[N-1].rem[gda_pkg::DayW-1:0], s[N-1].month, s[N-1].year};

endmodule
